>>> src/i2c_mwa_pkg.sv
// Shared types, codes and constants of the I2C multi-master write arbiter.
package i2c_mwa_pkg;

  // Buffer geometry.
  localparam int MAX_BYTES = 16;
  localparam int BCNT_W    = $clog2(MAX_BYTES + 1);
  localparam int BADDR_W   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  // Stream payload widths.
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  // Input item kinds.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Completion status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NACK      = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_HALF_PERIOD = 1'b1;

  // Configuration reset values.
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd3;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

  // Bus sequencer phases, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE      = 14'b00000000000001,
    PH_CHECK     = 14'b00000000000010,
    PH_START     = 14'b00000000000100,
    PH_START_LOW = 14'b00000000001000,
    PH_SETUP     = 14'b00000000010000,
    PH_HIGH      = 14'b00000000100000,
    PH_LOW       = 14'b00000001000000,
    PH_ACK_SETUP = 14'b00000010000000,
    PH_ACK_HIGH  = 14'b00000100000000,
    PH_ACK_LOW   = 14'b00001000000000,
    PH_STOP_A    = 14'b00010000000000,
    PH_STOP_B    = 14'b00100000000000,
    PH_STOP_C    = 14'b01000000000000,
    PH_BACKOFF   = 14'b10000000000000
  } phase_t;

  // One input item.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [6:0] target_address;
    logic       sda_level;
    logic       scl_level;
  } item_t;

  // One configuration write.
  typedef struct packed {
    logic        wr;
    logic        index;
    logic [15:0] data;
  } cfg_wr_t;

  // One result item.
  typedef struct packed {
    logic       sda_release;
    logic       scl_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] retries_used;
    logic       arb_loss;
  } res_t;

endpackage

>>> src/i2c_multi_master_write_arbiter.sv
// I2C multi-master write arbiter: sequencer plus output skid buffer.
// A result reaches m_axis through the output register, passing first through the skid register while m_axis stalls.
// Throughput: one item per cycle while the skid register is empty; the state update for an item is single-pass logic.
// A two-entry output buffer keeps s_axis_tready high while one result waits.
// Reset (rst, synchronous): sequencer idle, buffer empty, registers at 3 and 100.
// Configuration writes are always accepted and take effect on the next cycle.
module i2c_multi_master_write_arbiter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // data_byte[7:0], target_address[14:8], sda_level[15], scl_level[16], zero[23:17]
  input  logic [i2c_mwa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [i2c_mwa_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sda_release[0], scl_release[1], busy_res[2], done_res[3], status[5:4],
  // retries_used[13:6], arb_loss[14], zero[15]
  output logic [i2c_mwa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [15:0]                        cfg_data
);
  import i2c_mwa_pkg::*;

  item_t   item;
  cfg_wr_t cfg;
  res_t    core_res;
  res_t    out_res;
  logic    in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  // Unpack the input transfer.
  assign item.opcode         = s_axis_tuser;
  assign item.data_byte      = s_axis_tdata[7:0];
  assign item.target_address = s_axis_tdata[14:8];
  assign item.sda_level      = s_axis_tdata[15];
  assign item.scl_level      = s_axis_tdata[16];

  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  i2c_mwa_core u_core (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .item    (item),
    .cfg     (cfg),
    .res     (core_res)
  );

  i2c_mwa_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_res    (core_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Pack the result transfer.
  assign m_axis_tdata = {1'b0, out_res.arb_loss, out_res.retries_used, out_res.status,
                         out_res.done_res, out_res.busy_res, out_res.scl_release,
                         out_res.sda_release};

endmodule

>>> src/i2c_mwa_core.sv
// Bus sequencer: state registers, byte buffer and per-item next-state logic.
module i2c_mwa_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  i2c_mwa_pkg::item_t    item,
  input  i2c_mwa_pkg::cfg_wr_t  cfg,
  output i2c_mwa_pkg::res_t     res
);
  import i2c_mwa_pkg::*;

  // Configuration registers.
  logic [7:0]  retry_limit;
  logic [15:0] half_period_ticks;

  // Sequencer state.
  phase_t              phase, phase_next;
  logic [7:0]          byte_store [MAX_BYTES];
  logic [BCNT_W-1:0]   byte_count, byte_count_next;
  logic [BCNT_W-1:0]   byte_index, byte_index_next;
  logic [2:0]          bit_index, bit_index_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic [6:0]          address_reg, address_reg_next;
  logic [15:0]         delay_count, delay_count_next;
  logic [7:0]          retries_done, retries_done_next;
  logic                nack_seen, nack_seen_next;

  logic                store_wr;
  logic [BADDR_W-1:0]  rd_addr;
  logic [7:0]          rd_byte;
  logic [15:0]         hp;
  logic                stretchy;
  logic                done_p;
  logic [1:0]          status_p;
  logic                arb_p;
  logic                bit_out;

  assign hp       = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign stretchy = (phase == PH_HIGH) || (phase == PH_ACK_HIGH) || (phase == PH_STOP_B);
  assign rd_addr  = BADDR_W'(byte_index - BCNT_W'(1));
  assign rd_byte  = byte_store[rd_addr];

  // Next-state logic for one accepted item.
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    byte_index_next   = byte_index;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    address_reg_next  = address_reg;
    delay_count_next  = delay_count;
    retries_done_next = retries_done;
    nack_seen_next    = nack_seen;
    store_wr          = 1'b0;
    done_p            = 1'b0;
    status_p          = ST_OK;
    arb_p             = 1'b0;

    case (item.opcode)
      OP_LOAD: begin
        if (phase == PH_IDLE && byte_count < BCNT_W'(MAX_BYTES)) begin
          store_wr        = 1'b1;
          byte_count_next = byte_count + BCNT_W'(1);
        end
      end
      OP_START: begin
        if (phase == PH_IDLE) begin
          address_reg_next  = item.target_address;
          retries_done_next = 8'd0;
          byte_index_next   = '0;
          bit_index_next    = 3'd7;
          nack_seen_next    = 1'b0;
          if (retry_limit == 8'd0) begin
            phase_next       = PH_IDLE;
            delay_count_next = 16'd0;
            byte_count_next  = '0;
            done_p           = 1'b1;
            status_p         = ST_EXHAUSTED;
          end else begin
            phase_next       = PH_CHECK;
            delay_count_next = 16'd0;
          end
        end
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          if (stretchy && !item.scl_level) begin
            delay_count_next = 16'd0;
          end else if ({1'b0, delay_count} + 17'd1 < {1'b0, hp}) begin
            delay_count_next = delay_count + 16'd1;
          end else begin
            delay_count_next = 16'd0;
            unique case (phase)
              PH_CHECK: begin
                if (item.sda_level && item.scl_level) begin
                  phase_next = PH_START;
                end else begin
                  retries_done_next = retries_done + 8'd1;
                  if (retries_done_next >= retry_limit) begin
                    phase_next      = PH_IDLE;
                    byte_count_next = '0;
                    done_p          = 1'b1;
                    status_p        = ST_EXHAUSTED;
                  end else begin
                    phase_next = PH_CHECK;
                  end
                end
              end
              PH_START: phase_next = PH_START_LOW;
              PH_START_LOW: begin
                byte_index_next = '0;
                shift_byte_next = {address_reg, 1'b0};
                bit_index_next  = 3'd7;
                phase_next      = PH_SETUP;
              end
              PH_SETUP: phase_next = PH_HIGH;
              PH_HIGH: begin
                // A released one that reads back low means another master won.
                if (shift_byte[bit_index] && !item.sda_level) begin
                  retries_done_next = retries_done + 8'd1;
                  arb_p             = 1'b1;
                  phase_next        = PH_BACKOFF;
                end else begin
                  phase_next = PH_LOW;
                end
              end
              PH_LOW: begin
                if (bit_index == 3'd0) begin
                  phase_next = PH_ACK_SETUP;
                end else begin
                  bit_index_next = bit_index - 3'd1;
                  phase_next     = PH_SETUP;
                end
              end
              PH_ACK_SETUP: phase_next = PH_ACK_HIGH;
              PH_ACK_HIGH: begin
                nack_seen_next = item.sda_level;
                if (!item.sda_level) begin
                  byte_index_next = byte_index + BCNT_W'(1);
                end
                phase_next = PH_ACK_LOW;
              end
              PH_ACK_LOW: begin
                if (nack_seen || byte_index > byte_count || byte_index == '0 ||
                    byte_index > BCNT_W'(MAX_BYTES)) begin
                  phase_next = PH_STOP_A;
                end else begin
                  shift_byte_next = rd_byte;
                  bit_index_next  = 3'd7;
                  phase_next      = PH_SETUP;
                end
              end
              PH_STOP_A: phase_next = PH_STOP_B;
              PH_STOP_B: phase_next = PH_STOP_C;
              PH_STOP_C: begin
                phase_next      = PH_IDLE;
                byte_count_next = '0;
                done_p          = 1'b1;
                status_p        = nack_seen ? ST_NACK : ST_OK;
              end
              PH_BACKOFF: begin
                if (retries_done >= retry_limit) begin
                  phase_next      = PH_IDLE;
                  byte_count_next = '0;
                  done_p          = 1'b1;
                  status_p        = ST_EXHAUSTED;
                end else begin
                  phase_next = PH_CHECK;
                end
              end
              PH_IDLE: phase_next = PH_IDLE;
              default: phase_next = PH_IDLE;
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Line drive and status for the state left by the item.
  assign bit_out = shift_byte_next[bit_index_next];

  always_comb begin
    res.sda_release = 1'b1;
    res.scl_release = 1'b1;
    unique case (phase_next)
      PH_START:     begin res.sda_release = 1'b0;    res.scl_release = 1'b1; end
      PH_START_LOW: begin res.sda_release = 1'b0;    res.scl_release = 1'b0; end
      PH_SETUP:     begin res.sda_release = bit_out; res.scl_release = 1'b0; end
      PH_HIGH:      begin res.sda_release = bit_out; res.scl_release = 1'b1; end
      PH_LOW:       begin res.sda_release = bit_out; res.scl_release = 1'b0; end
      PH_ACK_SETUP: begin res.sda_release = 1'b1;    res.scl_release = 1'b0; end
      PH_ACK_LOW:   begin res.sda_release = 1'b1;    res.scl_release = 1'b0; end
      PH_STOP_A:    begin res.sda_release = 1'b0;    res.scl_release = 1'b0; end
      PH_STOP_B:    begin res.sda_release = 1'b0;    res.scl_release = 1'b1; end
      default:      begin res.sda_release = 1'b1;    res.scl_release = 1'b1; end
    endcase
    res.busy_res     = (phase_next != PH_IDLE);
    res.done_res     = done_p;
    res.status       = done_p ? status_p : ST_OK;
    res.retries_used = retries_done_next;
    res.arb_loss     = arb_p;
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit       <= RETRY_LIMIT_RESET;
      half_period_ticks <= HALF_PERIOD_RESET;
      phase             <= PH_IDLE;
      byte_count        <= '0;
      byte_index        <= '0;
      bit_index         <= 3'd7;
      shift_byte        <= 8'd0;
      address_reg       <= 7'd0;
      delay_count       <= 16'd0;
      retries_done      <= 8'd0;
      nack_seen         <= 1'b0;
    end else begin
      if (cfg.wr) begin
        unique case (cfg.index)
          CFG_RETRY_LIMIT: retry_limit       <= cfg.data[7:0];
          CFG_HALF_PERIOD: half_period_ticks <= cfg.data;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        byte_index   <= byte_index_next;
        bit_index    <= bit_index_next;
        shift_byte   <= shift_byte_next;
        address_reg  <= address_reg_next;
        delay_count  <= delay_count_next;
        retries_done <= retries_done_next;
        nack_seen    <= nack_seen_next;
      end
    end
  end

  // Byte buffer, written by load items only.
  always_ff @(posedge clk) begin
    if (in_fire && store_wr) begin
      byte_store[BADDR_W'(byte_count)] <= item.data_byte;
    end
  end

endmodule

>>> src/i2c_mwa_skid.sv
// Result register with a skid stage so input transfers continue under back-pressure.
module i2c_mwa_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2c_mwa_pkg::res_t  in_res,
  output logic               out_valid,
  input  logic               out_ready,
  output i2c_mwa_pkg::res_t  out_res
);
  import i2c_mwa_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_res <= skid_valid ? skid_res : in_res;
    end else if (in_fire) begin
      skid_res <= in_res;
    end
  end

endmodule

>>> src/i2c_mwa_checker.sv
// Port-level checks for the I2C multi-master write arbiter, bound to the top level.
module i2c_mwa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [i2c_mwa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import i2c_mwa_pkg::*;

  // A stalled result transfer stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A completion status is only reported together with done, and done ends the busy period.
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[5:4] != ST_OK) |-> m_axis_tdata[3] && !m_axis_tdata[2])
    else $error("status without done or done while busy");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[5:4] != 2'd3)
    else $error("invalid status code");

  // On arbitration loss the block backs off with both lines released.
  a_arb_release: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[2] && m_axis_tdata[1] && m_axis_tdata[0])
    else $error("lines driven after arbitration loss");

endmodule

bind i2c_multi_master_write_arbiter i2c_mwa_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
